/* rtl/core/bdqs_pkg.sv */
package bdqs_pkg;

	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = 32;

	typedef enum logic [2:0] {
		CMD_PUSH_HEAD = 3'd0,
		CMD_PUSH_TAIL = 3'd1,
		CMD_POP_HEAD  = 3'd2,
		CMD_POP_TAIL  = 3'd3,
		CMD_SEARCH    = 3'd4,
		CMD_MIN       = 3'd5,
		CMD_MAX       = 3'd6,
		CMD_REVERSE   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef logic signed [DW-1:0] data_t;

	typedef struct packed {
		cmd_t  cmd;
		data_t operand;
	} cmd_word_t;

	typedef struct packed {
		status_t         status;
		logic            found;
		data_t           result_value;
		logic [CW-1:0]   entry_count;
	} res_word_t;

	// one write port, one registered read port
	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		data_t         wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} mem_req_t;

endpackage

/* rtl/core/bdqs_store.sv */
module bdqs_store (
	input  logic               clk,
	input  bdqs_pkg::mem_req_t req,
	output bdqs_pkg::data_t    rd_data
);

	bdqs_pkg::data_t mem [bdqs_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

/* rtl/core/bdqs_ctrl.sv */
module bdqs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  bdqs_pkg::cmd_word_t cmd_word,
	output bdqs_pkg::mem_req_t  mem_req,
	input  bdqs_pkg::data_t     rd_data,
	output logic                done_valid,
	output bdqs_pkg::res_word_t done_word,
	input  logic                done_take
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                      state_q, state_nx;
	logic [bdqs_pkg::AW-1:0]     front_q, front_nx;
	logic [bdqs_pkg::CW-1:0]     cnt_q, cnt_nx;
	logic                        rev_q, rev_nx;
	logic [bdqs_pkg::CW-1:0]     iss_q, iss_nx;
	logic [bdqs_pkg::CW-1:0]     prc_q, prc_nx;
	logic                        rd_v_s1, rd_v_nx;
	logic                        first_q, first_nx;
	logic                        found_q, found_nx;
	bdqs_pkg::data_t             key_q, key_nx;
	bdqs_pkg::cmd_t              op_q, op_nx;
	bdqs_pkg::data_t             acc_q, acc_nx;
	bdqs_pkg::res_word_t         res_q, res_nx;

	logic full, empty, push_front, pop_front, hit, better, issue, last;

	assign full       = (cnt_q == bdqs_pkg::CW'(bdqs_pkg::DEPTH));
	assign empty      = (cnt_q == '0);
	assign push_front = (cmd_word.cmd == bdqs_pkg::CMD_PUSH_HEAD) ^ rev_q;
	assign pop_front  = (cmd_word.cmd == bdqs_pkg::CMD_POP_HEAD) ^ rev_q;
	assign hit        = (rd_data == key_q);
	assign better     = (op_q == bdqs_pkg::CMD_MIN) ? (rd_data < acc_q) : (acc_q < rd_data);
	assign issue      = (iss_q != cnt_q);
	assign last       = ((prc_q + bdqs_pkg::CW'(1)) == cnt_q);

	assign cmd_stall  = (state_q != S_IDLE);
	assign done_valid = (state_q == S_DONE);
	assign done_word  = res_q;

	always_comb begin
		state_nx = state_q;
		front_nx = front_q;
		cnt_nx   = cnt_q;
		rev_nx   = rev_q;
		iss_nx   = iss_q;
		prc_nx   = prc_q;
		rd_v_nx  = 1'b0;
		first_nx = first_q;
		found_nx = found_q;
		key_nx   = key_q;
		op_nx    = op_q;
		acc_nx   = acc_q;
		res_nx   = res_q;

		mem_req       = '0;
		mem_req.waddr = front_q + cnt_q[bdqs_pkg::AW-1:0];
		mem_req.wdata = cmd_word.operand;
		mem_req.raddr = front_q + iss_q[bdqs_pkg::AW-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					key_nx = cmd_word.operand;
					op_nx  = cmd_word.cmd;
					res_nx = '{status: bdqs_pkg::STAT_OK, found: 1'b0,
						result_value: '0, entry_count: cnt_q};
					state_nx = S_DONE;
					unique case (cmd_word.cmd) inside
						bdqs_pkg::CMD_PUSH_HEAD, bdqs_pkg::CMD_PUSH_TAIL: begin
							if (full) begin
								res_nx.status = bdqs_pkg::STAT_FULL;
							end else begin
								mem_req.we = 1'b1;
								if (push_front) begin
									front_nx      = front_q - bdqs_pkg::AW'(1);
									mem_req.waddr = front_q - bdqs_pkg::AW'(1);
								end
								cnt_nx             = cnt_q + bdqs_pkg::CW'(1);
								res_nx.entry_count = cnt_q + bdqs_pkg::CW'(1);
							end
						end
						bdqs_pkg::CMD_POP_HEAD, bdqs_pkg::CMD_POP_TAIL: begin
							if (empty) begin
								res_nx.status = bdqs_pkg::STAT_EMPTY;
							end else begin
								if (pop_front) begin
									front_nx = front_q + bdqs_pkg::AW'(1);
								end
								cnt_nx             = cnt_q - bdqs_pkg::CW'(1);
								res_nx.entry_count = cnt_q - bdqs_pkg::CW'(1);
							end
						end
						bdqs_pkg::CMD_SEARCH, bdqs_pkg::CMD_MIN, bdqs_pkg::CMD_MAX: begin
							if (empty) begin
								if (cmd_word.cmd != bdqs_pkg::CMD_SEARCH) begin
									res_nx.status = bdqs_pkg::STAT_EMPTY;
								end
							end else begin
								state_nx = S_SCAN;
								iss_nx   = '0;
								prc_nx   = '0;
								first_nx = 1'b1;
								found_nx = 1'b0;
							end
						end
						bdqs_pkg::CMD_REVERSE: begin
							rev_nx = ~rev_q;
						end
					endcase
				end
			end
			S_SCAN: begin
				// reads issue one entry ahead of the compare
				if (issue) begin
					mem_req.re = 1'b1;
					iss_nx     = iss_q + bdqs_pkg::CW'(1);
					rd_v_nx    = 1'b1;
				end
				if (rd_v_s1) begin
					found_nx = found_q | hit;
					if (first_q || better) begin
						acc_nx = rd_data;
					end
					first_nx = 1'b0;
					prc_nx   = prc_q + bdqs_pkg::CW'(1);
					if (last) begin
						state_nx = S_DONE;
						res_nx   = '{status: bdqs_pkg::STAT_OK, found: 1'b0,
							result_value: '0, entry_count: cnt_q};
						if (op_q == bdqs_pkg::CMD_SEARCH) begin
							res_nx.found = found_nx;
						end else begin
							res_nx.result_value = acc_nx;
						end
					end
				end
			end
			S_DONE: begin
				if (done_take) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			cnt_q   <= '0;
			rev_q   <= 1'b0;
			iss_q   <= '0;
			prc_q   <= '0;
			rd_v_s1 <= 1'b0;
			first_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			front_q <= front_nx;
			cnt_q   <= cnt_nx;
			rev_q   <= rev_nx;
			iss_q   <= iss_nx;
			prc_q   <= prc_nx;
			rd_v_s1 <= rd_v_nx;
			first_q <= first_nx;
			found_q <= found_nx;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_nx;
		op_q  <= op_nx;
		acc_q <= acc_nx;
		res_q <= res_nx;
	end

endmodule

/* rtl/core/bounded_deque_with_search_unit.sv */
// Bounded double-ended queue of up to 64 signed 32-bit entries in a ring memory.
// Command channel: cmd_valid / cmd_stall / cmd_word (cmd, operand). A word is
// taken at a clock edge with cmd_valid high and cmd_stall low.
// Result channel: res_valid / res_stall / res_word (status, found, result_value,
// entry_count). Exactly one result word per command, in command order.
// Push, pop and reverse need no memory read: the result is registered in the
// controller and then moved into the output register, and the next command
// can be taken once the controller has handed its result on.
// Search, minimum and maximum walk the stored entries through the memory's
// single registered read port, one entry per cycle, issuing each read ahead
// of the compare; no new command is taken until the result is handed on.
// On an empty queue they skip the walk: search returns status OK with found
// low, while minimum and maximum return STAT_EMPTY.
// An output register sits on the result side, so a new command is taken and
// worked on while a finished result waits under res_stall; a second finished
// result is held internally and cmd_stall stays high until it moves out.
// arst_n empties the queue, clears the reverse flag and drops any pending
// result; memory contents are not cleared and need no clearing pass.
module bounded_deque_with_search_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  bdqs_pkg::cmd_word_t cmd_word,
	output logic                res_valid,
	input  logic                res_stall,
	output bdqs_pkg::res_word_t res_word
);

	bdqs_pkg::mem_req_t  mem_req;
	bdqs_pkg::data_t     rd_data;
	logic                done_valid;
	bdqs_pkg::res_word_t done_word;
	logic                done_take;
	logic                out_vld_q;
	bdqs_pkg::res_word_t out_q;

	bdqs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_word   (cmd_word),
		.mem_req    (mem_req),
		.rd_data    (rd_data),
		.done_valid (done_valid),
		.done_word  (done_word),
		.done_take  (done_take)
	);

	bdqs_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	assign done_take = done_valid && (!out_vld_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (done_take) begin
			out_vld_q <= 1'b1;
		end else if (!res_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_take) begin
			out_q <= done_word;
		end
	end

	assign res_valid = out_vld_q;
	assign res_word  = out_q;

endmodule
